/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared payload types, round constants and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha_block_ram.sv */
// ----------------------------------------------------------------------------
// SHA block word memory
// 16 x 32 message word store with registered read.
// ----------------------------------------------------------------------------
module sha_block_ram (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);
  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/sha_core.sv */
// ----------------------------------------------------------------------------
// SHA round engine
// Runs 64 rounds over a 16-word window of schedule registers, one a cycle.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        load,
  input  logic [31:0] load_word,
  input  logic        load_last,
  input  logic        init_hash,
  input  logic [2:0]  hash_sel,
  output logic [31:0] hash_word,
  output logic        busy
);
  import sha_pkg::*;

  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  t;
  logic        run;
  logic        fin;
  logic [31:0] wn, s0, s1, ch, maj, t1, t2, g0, g1;

  assign hash_word = h[hash_sel];
  assign busy = run | fin;

  always_comb begin
    g0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    g1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + g0 + w[9] + g1;
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + round_k(t) + w[0];
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      t   <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[i];
    end else begin
      if (load) begin
        // shift the window; the first word ends at w[0]
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= load_word;
        if (load_last) begin
          run <= 1'b1;
          t   <= '0;
        end
      end
      if (start) for (int i = 0; i < 8; i++) v[i] <= h[i];
      if (run) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wn;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        t <= t + 6'd1;
        if (t == 6'd63) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
      if (fin) begin
        fin <= 1'b0;
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      end
      if (init_hash) for (int i = 0; i < 8; i++) h[i] <= INIT_HASH[i];
    end
  end
endmodule

/* rtl/sha256_message_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-serial SHA-256 with padding and digest output.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready carrying one byte, a present flag and
// an end flag. Bytes are packed into 32-bit words held in a 16-entry block
// memory (registered read). A plain byte is taken without leaving S_IDLE;
// no request is taken while a block is loaded, padded or hashed. When a
// block fills, its 16 words are read from memory into the round engine,
// then 64 rounds run at one round a cycle, the fin step folds them into the
// hash and S_RUN hands back control.
// An end request pads in memory (up to 16 word writes), compresses one or
// two blocks, then emits eight digest words on out_valid/out_ready, word 0
// first, last_word on word 7. The hash then reloads its initial values and
// the bit count clears. A stalled receiver holds the output register and the
// block takes no new request until all eight words are taken.
// Reset restores the initial hash and clears the bit count; the block memory
// is not cleared, each entry is written before it is read.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_RUN  = 7'b0000100,
    S_PAD  = 7'b0001000,
    S_LEN  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t      state;
  logic [63:0] bit_count;
  logic [31:0] word_acc;
  logic [4:0]  ld_cnt;
  logic [3:0]  pad_idx;
  logic        ending;
  logic        pad_pending;
  logic        len_pending;
  logic [2:0]  out_idx;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic        core_start, core_load, core_last, core_init, core_busy;
  logic [31:0] core_hash;
  logic [5:0]  pos;
  logic [5:0]  pos_next;
  logic [1:0]  bsel;
  logic [31:0] acc_byte;
  logic [31:0] pad_word;

  assign pos  = bit_count[8:3];
  assign pos_next = in_data.byte_present ? pos + 6'd1 : pos;
  assign bsel = pos[1:0];
  assign in_ready = (state == S_IDLE);

  always_comb begin
    acc_byte = word_acc;
    case (bsel)
      2'd0: acc_byte[31:24] = in_data.data_byte;
      2'd1: acc_byte[23:16] = in_data.data_byte;
      2'd2: acc_byte[15:8]  = in_data.data_byte;
      default: acc_byte[7:0] = in_data.data_byte;
    endcase
  end

  // padding word at pad_idx: partial word gets 0x80 after the kept bytes
  always_comb begin
    pad_word = '0;
    if (state == S_PAD && pad_idx == pos[5:2]) begin
      case (bsel)
        2'd0: pad_word = {PAD_BYTE, 24'h0};
        2'd1: pad_word = {word_acc[31:24], PAD_BYTE, 16'h0};
        2'd2: pad_word = {word_acc[31:16], PAD_BYTE, 8'h0};
        default: pad_word = {word_acc[31:8], PAD_BYTE};
      endcase
    end
    // a tail of 56 bytes or more leaves the length for a second block
    if (len_pending && (state == S_LEN || pos < 6'd56)) begin
      if (pad_idx == 4'd14) pad_word = bit_count[63:32];
      if (pad_idx == 4'd15) pad_word = bit_count[31:0];
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pos[5:2];
    ram_wdata = acc_byte;
    if (state == S_IDLE && in_valid && in_data.byte_present && bsel == 2'd3) ram_we = 1'b1;
    if (state == S_PAD || state == S_LEN) begin
      ram_we = 1'b1;
      ram_waddr = pad_idx;
      ram_wdata = pad_word;
    end
  end

  assign ram_raddr  = ld_cnt[3:0];
  assign core_start = (state == S_LOAD) && (ld_cnt == 5'd0);
  assign core_load  = (state == S_LOAD) && (ld_cnt != 5'd0);
  assign core_last  = (ld_cnt == 5'd16);
  assign core_init  = (state == S_OUT) && out_ready && out_idx == 3'd7;

  sha_block_ram u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .load(core_load),
    .load_word(ram_rdata), .load_last(core_last), .init_hash(core_init),
    .hash_sel(out_idx), .hash_word(core_hash), .busy(core_busy)
  );

  assign out_valid = (state == S_OUT);
  assign out_data.digest_word = core_hash;
  assign out_data.word_index  = out_idx;
  assign out_data.last_word   = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bit_count <= '0;
      ld_cnt <= '0;
      pad_idx <= '0;
      ending <= 1'b0;
      pad_pending <= 1'b0;
      len_pending <= 1'b0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ending <= in_data.message_end;
            pad_pending <= in_data.message_end;
            len_pending <= in_data.message_end;
            if (in_data.byte_present) begin
              word_acc <= acc_byte;
              bit_count <= bit_count + 64'd8;
            end
            pad_idx <= pos_next[5:2];
            ld_cnt <= '0;
            if (in_data.byte_present && pos == 6'd63) state <= S_LOAD;
            else if (in_data.message_end) state <= S_PAD;
          end
        end
        S_LOAD: begin
          ld_cnt <= ld_cnt + 5'd1;
          if (ld_cnt == 5'd16) state <= S_RUN;
        end
        S_RUN: begin
          ld_cnt <= '0;
          if (!core_busy) begin
            if (ending && pad_pending) begin
              state <= S_PAD;
              pad_idx <= pos[5:2];
            end else if (ending && len_pending) begin
              state <= S_LEN;
              pad_idx <= '0;
            end else if (ending) begin
              state <= S_OUT;
              out_idx <= '0;
            end else state <= S_IDLE;
          end
        end
        S_PAD: begin
          // fill from the current word to the end of the block
          pad_idx <= pad_idx + 4'd1;
          if (pad_idx == 4'd15) begin
            state <= S_LOAD;
            pad_pending <= 1'b0;
            if (pos < 6'd56) len_pending <= 1'b0;
          end
        end
        S_LEN: begin
          // second block: zeros then the length
          pad_idx <= pad_idx + 4'd1;
          if (pad_idx == 4'd15) begin
            state <= S_LOAD;
            len_pending <= 1'b0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state <= S_WAIT;
              bit_count <= '0;
            end
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/sha_checker.sv */
// ----------------------------------------------------------------------------
// SHA hasher port checker
// Watches handshake and digest word order on the top-level ports.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sha_pkg::sha_out_t out_data
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input request dropped before it was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request dropped or changed while stalled");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word out of step with word_index");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest words not consecutive");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while digest pending");
endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
